FILE: hdl/uct_pkg.sv
// Shared types, codes and character class decode for the URI tokenizer.
// No dependencies; imported by uri_component_tokenizer_core.
`timescale 1ns / 1ps
`default_nettype none

package uct_pkg;

    localparam int CH_W      = 16;
    localparam int KIND_W    = 3;
    localparam int START_W   = 12;
    localparam int TLEN_W    = 13;
    localparam int SEG_W     = 12;
    localparam int STAT_W    = 2;
    localparam int ERR_W     = 13;

    localparam int MAX_LEN_DEF = 4096;
    localparam int MAX_RES     = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [CH_W-1:0] CH_SLASH = 16'h002F;
    localparam logic [CH_W-1:0] CH_QMARK = 16'h003F;
    localparam logic [CH_W-1:0] CH_HASH  = 16'h0023;
    localparam logic [CH_W-1:0] CH_COLON = 16'h003A;

    typedef enum logic [KIND_W-1:0] {
        KIND_SCHEME = 3'd0,
        KIND_AUTH   = 3'd1,
        KIND_SEG    = 3'd2,
        KIND_QUERY  = 3'd3,
        KIND_FRAG   = 3'd4,
        KIND_PATH   = 3'd5,
        KIND_STATUS = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_BAD   = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [9:0] {
        ST_NONE       = 10'b00_0000_0001,
        ST_NONE_SLASH = 10'b00_0000_0010,
        ST_AMBIG      = 10'b00_0000_0100,
        ST_POSTSCHEME = 10'b00_0000_1000,
        ST_POST_SLASH = 10'b00_0001_0000,
        ST_AUTH       = 10'b00_0010_0000,
        ST_PATH       = 10'b00_0100_0000,
        ST_QUERY      = 10'b00_1000_0000,
        ST_FRAG       = 10'b01_0000_0000,
        ST_DROP       = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [START_W-1:0]  tok_start;
        logic [TLEN_W-1:0]   tok_len;
        logic [SEG_W-1:0]    seg_num;
        status_t             status;
        logic [ERR_W-1:0]    error_pos;
        logic                last;
    } result_t;

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        return ((c >= 16'h0061) && (c <= 16'h007A)) || ((c >= 16'h0041) && (c <= 16'h005A));
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return (c >= 16'h0030) && (c <= 16'h0039);
    endfunction

    function automatic logic is_scheme_more(input logic [CH_W-1:0] c);
        return is_alpha(c) || is_digit(c) ||
               (c == 16'h002B) || (c == 16'h002D) || (c == 16'h002E);
    endfunction

    // Unreserved marks, sub-delimiters and the extra path marks.
    function automatic logic is_path_mark(input logic [CH_W-1:0] c);
        logic hit;
        case (c)
            16'h002D, 16'h002E, 16'h005F, 16'h007E,
            16'h0021, 16'h0024, 16'h0026, 16'h0027, 16'h0028, 16'h0029,
            16'h002A, 16'h002B, 16'h002C, 16'h003B, 16'h003D,
            16'h003A, 16'h0040, 16'h0025, 16'h007B, 16'h007D,
            16'h003C, 16'h003E, 16'h005E: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_path_char(input logic [CH_W-1:0] c);
        return is_alpha(c) || is_digit(c) || is_path_mark(c);
    endfunction

    function automatic result_t mk_token(input kind_t k,
                                         input logic [START_W-1:0] s,
                                         input logic [TLEN_W-1:0] l,
                                         input logic [SEG_W-1:0] seg);
        result_t r;
        r           = '0;
        r.kind      = k;
        r.tok_start = s;
        r.tok_len   = l;
        r.seg_num   = seg;
        r.status    = STAT_OK;
        return r;
    endfunction

    function automatic result_t mk_status(input status_t st, input logic [ERR_W-1:0] err);
        result_t r;
        r           = '0;
        r.kind      = KIND_STATUS;
        r.status    = st;
        r.error_pos = err;
        r.last      = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/uri_component_tokenizer_core.sv
// URI component tokenizer: character decode, parse state and result queue.
// Depends on uct_pkg for types, codes and character classes.
`timescale 1ns / 1ps
`default_nettype none

// Takes a URI one 16-bit character beat per cycle while item_ready is high,
// closed by an end beat (is_end high). Each character beat is decoded and
// the parse state updated in the cycle it is accepted. A beat raises up to
// three result beats (token, full path, status on an end beat). They land
// in an 8-entry result queue at the accepting edge and move one per cycle,
// while the output register is free or being read, into that register,
// so the first result of a beat passes the queue and then the output
// register. Results leave one per cycle while res_ready is high. item_ready
// drops only while the queue has fewer than three free entries, which
// happens when results are taken slower than they are raised. After a syntax
// error the status beat is sent at once and the rest of the string,
// including its end beat, is swallowed without results. Strings longer
// than MAX_LEN characters fail at the first character past the limit.
module uri_component_tokenizer_core
    import uct_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_ready,
    input  wire  [CH_W-1:0]     ch,
    input  wire                 is_end,
    output logic                res_valid,
    input  wire                 res_ready,
    output logic [KIND_W-1:0]   kind,
    output logic [START_W-1:0]  tok_start,
    output logic [TLEN_W-1:0]   tok_len,
    output logic [SEG_W-1:0]    seg_num,
    output logic [STAT_W-1:0]   status,
    output logic [ERR_W-1:0]    error_pos,
    output logic                last
);

    // Positions, offsets and lengths never exceed MAX_LEN inside the block.
    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(FIFO_DEPTH - MAX_RES);

    // Parse state
    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   tstart_reg, tstart_next;
    logic [POS_W-1:0]   tlen_reg, tlen_next;
    logic [SEG_W-1:0]   segcnt_reg, segcnt_next;
    logic [POS_W-1:0]   pstart_reg, pstart_next;
    logic [POS_W-1:0]   plen_reg, plen_next;

    // Result queue
    result_t            fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Output register
    result_t            head_reg;
    logic               head_valid_reg, head_valid_next;
    logic               load_head;

    // Per-beat decode
    result_t            res [MAX_RES];
    logic [1:0]         n_res;
    logic               item_acc;
    logic               res_acc;
    logic               use_pc;
    logic               close_extra;
    logic               do_close;
    state_t             pc_state;
    logic [POS_W-1:0]   pc_start;
    logic [POS_W-1:0]   pc_len;
    logic [POS_W-1:0]   fin_pstart;
    logic [POS_W-1:0]   fin_plen;

    assign item_ready = (count_reg <= READY_LIMIT);
    assign item_acc   = item_valid && item_ready;
    assign res_valid  = head_valid_reg;
    assign res_acc    = res_valid && res_ready;
    // Advance the queue head into the output register when it is free or leaving.
    assign load_head  = (count_reg != '0) && (!head_valid_reg || res_ready);

    // Character and end beat decode: one state transition per beat.
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        segcnt_next = segcnt_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = '0;
        end
        n_res       = 2'd0;
        use_pc      = 1'b0;
        close_extra = 1'b0;
        do_close    = 1'b0;
        pc_state    = ST_PATH;
        pc_start    = tstart_reg;
        pc_len      = tlen_reg;
        fin_pstart  = pstart_reg;
        fin_plen    = plen_reg;

        if (is_end)
        begin
            // Close the open token, then full path, then status.
            case (state_reg)
                ST_DROP:
                begin
                end
                ST_NONE:
                begin
                    res[n_res] = mk_status(STAT_EMPTY, '0);
                    n_res      = n_res + 2'd1;
                end
                ST_AMBIG, ST_PATH:
                begin
                    if (segcnt_reg == '0)
                    begin
                        fin_pstart = tstart_reg;
                        if (tlen_reg != '0)
                        begin
                            res[n_res] = mk_token(KIND_SEG, START_W'(tstart_reg),
                                                  TLEN_W'(tlen_reg), '0);
                            n_res      = n_res + 2'd1;
                        end
                    end
                    else
                    begin
                        res[n_res] = mk_token(KIND_SEG, START_W'(tstart_reg),
                                              TLEN_W'(tlen_reg), segcnt_reg);
                        n_res      = n_res + 2'd1;
                    end
                    fin_plen = plen_reg + tlen_reg;
                end
                ST_POSTSCHEME:
                begin
                    res[n_res] = mk_token(KIND_SCHEME, START_W'(tstart_reg),
                                          TLEN_W'(tlen_reg), '0);
                    n_res      = n_res + 2'd1;
                end
                ST_AUTH:
                begin
                    res[n_res] = mk_token(KIND_AUTH, START_W'(tstart_reg),
                                          TLEN_W'(tlen_reg), '0);
                    n_res      = n_res + 2'd1;
                end
                ST_QUERY:
                begin
                    res[n_res] = mk_token(KIND_QUERY, START_W'(tstart_reg),
                                          TLEN_W'(tlen_reg), '0);
                    n_res      = n_res + 2'd1;
                end
                ST_FRAG:
                begin
                    res[n_res] = mk_token(KIND_FRAG, START_W'(tstart_reg),
                                          TLEN_W'(tlen_reg), '0);
                    n_res      = n_res + 2'd1;
                end
                default:
                begin
                end
            endcase
            if ((state_reg != ST_DROP) && (state_reg != ST_NONE))
            begin
                if (fin_plen != '0)
                begin
                    res[n_res] = mk_token(KIND_PATH, START_W'(fin_pstart),
                                          TLEN_W'(fin_plen), '0);
                    n_res      = n_res + 2'd1;
                end
                res[n_res] = mk_status(STAT_OK, '0);
                n_res      = n_res + 2'd1;
            end
            // Start a new string.
            state_next  = ST_NONE;
            pos_next    = '0;
            tstart_next = '0;
            tlen_next   = '0;
            segcnt_next = '0;
            pstart_next = '0;
            plen_next   = '0;
        end
        else if (state_reg != ST_DROP)
        begin
            if (pos_reg >= MAX_POS)
            begin
                state_next = ST_DROP;
                res[0]     = mk_status(STAT_BAD, ERR_W'(pos_reg));
                n_res      = 2'd1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                case (state_reg)
                    ST_NONE:
                    begin
                        if (ch == CH_SLASH)
                        begin
                            state_next = ST_NONE_SLASH;
                        end
                        else if (is_path_char(ch))
                        begin
                            tstart_next = pos_reg;
                            tlen_next   = POS_W'(1);
                            state_next  = is_alpha(ch) ? ST_AMBIG : ST_PATH;
                        end
                        else
                        begin
                            state_next = ST_DROP;
                            res[0]     = mk_status(STAT_BAD, ERR_W'(pos_reg));
                            n_res      = 2'd1;
                        end
                    end
                    ST_NONE_SLASH, ST_POST_SLASH:
                    begin
                        if (ch == CH_SLASH)
                        begin
                            tstart_next = pos_next;
                            tlen_next   = '0;
                            state_next  = ST_AUTH;
                        end
                        else
                        begin
                            use_pc   = 1'b1;
                            pc_state = ST_PATH;
                            pc_start = pos_reg;
                            pc_len   = '0;
                        end
                    end
                    ST_AMBIG:
                    begin
                        if (ch == CH_COLON)
                        begin
                            res[0]     = mk_token(KIND_SCHEME, START_W'(tstart_reg),
                                                  TLEN_W'(tlen_reg), '0);
                            n_res      = 2'd1;
                            state_next = ST_POSTSCHEME;
                        end
                        else
                        begin
                            use_pc   = 1'b1;
                            pc_state = ST_AMBIG;
                        end
                    end
                    ST_POSTSCHEME:
                    begin
                        if (ch == CH_SLASH)
                        begin
                            state_next = ST_POST_SLASH;
                        end
                        else if ((ch == CH_QMARK) || (ch == CH_HASH))
                        begin
                            tstart_next = pos_next;
                            tlen_next   = '0;
                            state_next  = (ch == CH_QMARK) ? ST_QUERY : ST_FRAG;
                        end
                        else if (is_path_char(ch))
                        begin
                            tstart_next = pos_reg;
                            tlen_next   = POS_W'(1);
                            state_next  = ST_PATH;
                        end
                        else
                        begin
                            state_next = ST_DROP;
                            res[0]     = mk_status(STAT_BAD, ERR_W'(pos_reg));
                            n_res      = 2'd1;
                        end
                    end
                    ST_AUTH:
                    begin
                        if ((ch == CH_SLASH) || (ch == CH_QMARK) || (ch == CH_HASH))
                        begin
                            res[0]      = mk_token(KIND_AUTH, START_W'(tstart_reg),
                                                   TLEN_W'(tlen_reg), '0);
                            n_res       = 2'd1;
                            tstart_next = pos_next;
                            tlen_next   = '0;
                            if (ch == CH_SLASH)
                            begin
                                state_next = ST_PATH;
                            end
                            else if (ch == CH_QMARK)
                            begin
                                state_next = ST_QUERY;
                            end
                            else
                            begin
                                state_next = ST_FRAG;
                            end
                        end
                        else
                        begin
                            tlen_next = tlen_reg + POS_W'(1);
                        end
                    end
                    ST_PATH:
                    begin
                        use_pc   = 1'b1;
                        pc_state = ST_PATH;
                    end
                    ST_QUERY:
                    begin
                        if (ch == CH_HASH)
                        begin
                            res[0]      = mk_token(KIND_QUERY, START_W'(tstart_reg),
                                                   TLEN_W'(tlen_reg), '0);
                            n_res       = 2'd1;
                            tstart_next = pos_next;
                            tlen_next   = '0;
                            state_next  = ST_FRAG;
                        end
                        else
                        begin
                            tlen_next = tlen_reg + POS_W'(1);
                        end
                    end
                    ST_FRAG:
                    begin
                        tlen_next = tlen_reg + POS_W'(1);
                    end
                    default:
                    begin
                        state_next = ST_DROP;
                    end
                endcase

                // Segment character handling, shared by leading text and path.
                if (use_pc)
                begin
                    if (ch == CH_SLASH)
                    begin
                        do_close    = 1'b1;
                        close_extra = 1'b1;
                        state_next  = ST_PATH;
                    end
                    else if (is_path_char(ch))
                    begin
                        tstart_next = pc_start;
                        tlen_next   = pc_len + POS_W'(1);
                        state_next  = ((pc_state == ST_AMBIG) && is_scheme_more(ch)) ?
                                      ST_AMBIG : ST_PATH;
                    end
                    else if ((ch == CH_QMARK) || (ch == CH_HASH))
                    begin
                        do_close   = 1'b1;
                        state_next = (ch == CH_QMARK) ? ST_QUERY : ST_FRAG;
                    end
                    else
                    begin
                        state_next = ST_DROP;
                        res[0]     = mk_status(STAT_BAD, ERR_W'(pos_reg));
                        n_res      = 2'd1;
                    end
                    if (do_close)
                    begin
                        if (segcnt_reg == '0)
                        begin
                            pstart_next = pc_start;
                        end
                        plen_next   = plen_reg + pc_len + {{(POS_W-1){1'b0}}, close_extra};
                        res[0]      = mk_token(KIND_SEG, START_W'(pc_start),
                                               TLEN_W'(pc_len), segcnt_reg);
                        n_res       = 2'd1;
                        segcnt_next = segcnt_reg + SEG_W'(1);
                        tstart_next = pos_next;
                        tlen_next   = '0;
                    end
                end
            end
        end
    end

    // Queue pointers: push up to three beats, move one to the output register.
    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        count_next      = count_reg;
        head_valid_next = head_valid_reg;
        if (item_acc)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
            count_next  = count_next + CNT_W'(n_res);
        end
        if (load_head)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
        if (load_head)
        begin
            head_valid_next = 1'b1;
        end
        else if (res_acc)
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_NONE;
            pos_reg        <= '0;
            tstart_reg     <= '0;
            tlen_reg       <= '0;
            segcnt_reg     <= '0;
            pstart_reg     <= '0;
            plen_reg       <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_acc)
            begin
                state_reg  <= state_next;
                pos_reg    <= pos_next;
                tstart_reg <= tstart_next;
                tlen_reg   <= tlen_next;
                segcnt_reg <= segcnt_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
            end
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
        end
    end

    // Result storage and output register: hold payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                if (2'(i) < n_res)
                begin
                    fifo_mem[wr_ptr_reg + PTR_W'(i)] <= res[i];
                end
            end
        end
        if (load_head)
        begin
            head_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    assign kind      = head_reg.kind;
    assign tok_start = head_reg.tok_start;
    assign tok_len   = head_reg.tok_len;
    assign seg_num   = head_reg.seg_num;
    assign status    = head_reg.status;
    assign error_pos = head_reg.error_pos;
    assign last      = head_reg.last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count exceeds depth");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && is_end |=> (state_reg == ST_NONE) && (pos_reg == '0))
        else $error("end beat did not restart the string");

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && !is_end && (n_res != 2'd0) && (res[0].kind == KIND_STATUS)
        |=> (state_reg == ST_DROP))
        else $error("syntax error did not enter drop");

    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && (state_reg == ST_DROP) |-> (n_res == 2'd0))
        else $error("dropped string raised a result");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (last == (kind == KIND_STATUS)))
        else $error("last flag does not match status kind");
`endif

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for uri_component_tokenizer_core: streams URI character beats,
// predicts every token and status beat in-line and compares each result field by field.
// Depends on uct_pkg (types, widths, character codes) and the core RTL only.
`timescale 1ns / 1ps

module testbench;
    import uct_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int URI_LIMIT    = MAX_LEN_DEF;   // the core runs with its default length cap
    localparam int RANDOM_BEATS = 90;
    localparam int HOLD_CYCLES  = 300;           // long receiver hold-off to back up the core
    localparam int IDLE_LIMIT   = 3000;          // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 32;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [CH_W-1:0] code;
        logic            end_mark;
    } char_beat_t;

    // ------------------------------------------------------------------
    // Ports of the core
    // ------------------------------------------------------------------
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    logic [CH_W-1:0]     ch         = '0;
    logic                is_end     = 1'b0;
    logic                res_valid;
    logic                res_ready  = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [START_W-1:0]  tok_start;
    logic [TLEN_W-1:0]   tok_len;
    logic [SEG_W-1:0]    seg_num;
    logic [STAT_W-1:0]   status;
    logic [ERR_W-1:0]    error_pos;
    logic                last;

    uri_component_tokenizer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .ch         (ch),
        .is_end     (is_end),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .kind       (kind),
        .tok_start  (tok_start),
        .tok_len    (tok_len),
        .seg_num    (seg_num),
        .status     (status),
        .error_pos  (error_pos),
        .last       (last)
    );

    // ------------------------------------------------------------------
    // Bookkeeping shared by the processes
    // ------------------------------------------------------------------
    char_beat_t  uri_beats[$];        // character beats still to be sent
    result_t     expected_events[$];  // token/status beats the core still owes us
    char_beat_t  next_beat;
    result_t     seen;
    bit          in_fire     = 1'b0;
    bit          out_fire    = 1'b0;
    int unsigned beats_in    = 0;
    int unsigned beats_total = 0;
    int unsigned idle_cycles = 0;
    int unsigned fail_count  = 0;
    int unsigned hold_at     = 32'hFFFF_FFFF;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned run_left    = 0;
    bit          ready_phase = 1'b0;

    string path_alphabet =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~!$&'()*+,;=:@%{}<>^";
    string scheme_alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-.";

    // ------------------------------------------------------------------
    // Parser mirror: state of the string currently being tokenized
    // ------------------------------------------------------------------
    state_t      parse_st   = ST_NONE;
    int unsigned char_idx   = 0;
    int unsigned tok_from   = 0;
    int unsigned tok_count  = 0;
    int unsigned seg_count  = 0;
    int unsigned path_from  = 0;
    int unsigned path_count = 0;

    function automatic bit letter_char(logic [CH_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit numeral_char(logic [CH_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit scheme_tail_char(logic [CH_W-1:0] c);
        return letter_char(c) || numeral_char(c) || c == "+" || c == "-" || c == ".";
    endfunction

    function automatic bit path_ok_char(logic [CH_W-1:0] c);
        bit hit;
        case (c)
            "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=",
            ":", "@", "%", "{", "}", "<", ">", "^": hit = 1'b1;
            default: hit = letter_char(c) || numeral_char(c);
        endcase
        return hit;
    endfunction

    task automatic clear_parser();
        parse_st   = ST_NONE;
        char_idx   = 0;
        tok_from   = 0;
        tok_count  = 0;
        seg_count  = 0;
        path_from  = 0;
        path_count = 0;
    endtask

    // Queue one expected result beat, cut to the port widths.
    task automatic push_event(kind_t k, int unsigned from, int unsigned len,
                              int unsigned seg, status_t st, int unsigned err_at);
        result_t ev;
        ev.kind      = k;
        ev.tok_start = from[START_W-1:0];
        ev.tok_len   = len[TLEN_W-1:0];
        ev.seg_num   = seg[SEG_W-1:0];
        ev.status    = st;
        ev.error_pos = err_at[ERR_W-1:0];
        ev.last      = (k == KIND_STATUS);
        expected_events.push_back(ev);
    endtask

    task automatic flag_syntax_error(int unsigned at);
        parse_st = ST_DROP;
        push_event(KIND_STATUS, 0, 0, 0, STAT_BAD, at);
    endtask

    task automatic close_segment(int unsigned extra);
        if (seg_count == 0)
            path_from = tok_from;
        path_count += tok_count + extra;
        push_event(KIND_SEG, tok_from, tok_count, seg_count, STAT_OK, 0);
        seg_count = (seg_count + 1) & ((1 << SEG_W) - 1);
    endtask

    // One character inside a path segment, or inside the ambiguous leading token.
    task automatic path_step(logic [CH_W-1:0] c, int unsigned at);
        if (c == CH_SLASH)
        begin
            close_segment(1);
            parse_st  = ST_PATH;
            tok_from  = at + 1;
            tok_count = 0;
        end
        else if (path_ok_char(c))
        begin
            tok_count++;
            // keep the token ambiguous while it still looks like a scheme
            if (!(parse_st == ST_AMBIG && scheme_tail_char(c)))
                parse_st = ST_PATH;
        end
        else if (c == CH_QMARK || c == CH_HASH)
        begin
            close_segment(0);
            parse_st  = (c == CH_QMARK) ? ST_QUERY : ST_FRAG;
            tok_from  = at + 1;
            tok_count = 0;
        end
        else
        begin
            flag_syntax_error(at);
        end
    endtask

    // End beat: flush the open token, report the full path and the status.
    task automatic finish_string();
        case (parse_st)
            ST_NONE: push_event(KIND_STATUS, 0, 0, 0, STAT_EMPTY, 0);
            ST_AMBIG, ST_PATH:
            begin
                // a trailing empty segment only counts when segments came before it
                if (seg_count == 0)
                begin
                    path_from = tok_from;
                    if (tok_count != 0)
                        push_event(KIND_SEG, tok_from, tok_count, 0, STAT_OK, 0);
                end
                else
                begin
                    push_event(KIND_SEG, tok_from, tok_count, seg_count, STAT_OK, 0);
                end
                path_count += tok_count;
            end
            ST_POSTSCHEME: push_event(KIND_SCHEME, tok_from, tok_count, 0, STAT_OK, 0);
            ST_AUTH:       push_event(KIND_AUTH, tok_from, tok_count, 0, STAT_OK, 0);
            ST_QUERY:      push_event(KIND_QUERY, tok_from, tok_count, 0, STAT_OK, 0);
            ST_FRAG:       push_event(KIND_FRAG, tok_from, tok_count, 0, STAT_OK, 0);
            default: ;
        endcase
        if (parse_st != ST_DROP && parse_st != ST_NONE)
        begin
            if (path_count != 0)
                push_event(KIND_PATH, path_from, path_count, 0, STAT_OK, 0);
            push_event(KIND_STATUS, 0, 0, 0, STAT_OK, 0);
        end
        clear_parser();
    endtask

    task automatic predict_beat(logic [CH_W-1:0] c, logic end_mark);
        int unsigned at;
        at = char_idx;
        if (end_mark)
        begin
            finish_string();
        end
        else if (parse_st == ST_DROP)
        begin
            // rest of a failed string: swallow silently
        end
        else if (at >= URI_LIMIT)
        begin
            flag_syntax_error(at);
        end
        else
        begin
            char_idx = at + 1;
            case (parse_st)
                ST_NONE:
                begin
                    if (c == CH_SLASH)
                    begin
                        parse_st = ST_NONE_SLASH;
                    end
                    else if (letter_char(c))
                    begin
                        tok_from  = at;
                        tok_count = 1;
                        parse_st  = ST_AMBIG;
                    end
                    else if (path_ok_char(c))
                    begin
                        tok_from  = at;
                        tok_count = 1;
                        parse_st  = ST_PATH;
                    end
                    else
                    begin
                        flag_syntax_error(at);
                    end
                end
                ST_NONE_SLASH, ST_POST_SLASH:
                begin
                    // second slash opens the authority, anything else starts a path
                    if (c == CH_SLASH)
                    begin
                        tok_from  = at + 1;
                        tok_count = 0;
                        parse_st  = ST_AUTH;
                    end
                    else
                    begin
                        tok_from  = at;
                        tok_count = 0;
                        parse_st  = ST_PATH;
                        path_step(c, at);
                    end
                end
                ST_AMBIG:
                begin
                    if (c == CH_COLON)
                    begin
                        push_event(KIND_SCHEME, tok_from, tok_count, 0, STAT_OK, 0);
                        parse_st = ST_POSTSCHEME;
                    end
                    else
                    begin
                        path_step(c, at);
                    end
                end
                ST_POSTSCHEME:
                begin
                    if (c == CH_SLASH)
                    begin
                        parse_st = ST_POST_SLASH;
                    end
                    else if (c == CH_QMARK || c == CH_HASH)
                    begin
                        tok_from  = at + 1;
                        tok_count = 0;
                        parse_st  = (c == CH_QMARK) ? ST_QUERY : ST_FRAG;
                    end
                    else if (path_ok_char(c))
                    begin
                        tok_from  = at;
                        tok_count = 1;
                        parse_st  = ST_PATH;
                    end
                    else
                    begin
                        flag_syntax_error(at);
                    end
                end
                ST_AUTH:
                begin
                    if (c == CH_SLASH || c == CH_QMARK || c == CH_HASH)
                    begin
                        push_event(KIND_AUTH, tok_from, tok_count, 0, STAT_OK, 0);
                        tok_from  = at + 1;
                        tok_count = 0;
                        parse_st  = (c == CH_SLASH) ? ST_PATH :
                                    (c == CH_QMARK) ? ST_QUERY : ST_FRAG;
                    end
                    else
                    begin
                        tok_count++;
                    end
                end
                ST_PATH: path_step(c, at);
                ST_QUERY:
                begin
                    if (c == CH_HASH)
                    begin
                        push_event(KIND_QUERY, tok_from, tok_count, 0, STAT_OK, 0);
                        tok_from  = at + 1;
                        tok_count = 0;
                        parse_st  = ST_FRAG;
                    end
                    else
                    begin
                        tok_count++;
                    end
                end
                ST_FRAG: tok_count++;
                default: parse_st = ST_DROP;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_char(logic [CH_W-1:0] c);
        char_beat_t b;
        b.code     = c;
        b.end_mark = 1'b0;
        uri_beats.push_back(b);
    endtask

    // The character lane carries junk on an end beat; the core must ignore it.
    task automatic push_end();
        char_beat_t b;
        b.code     = CH_W'($urandom_range(0, 16'hFFFF));
        b.end_mark = 1'b1;
        uri_beats.push_back(b);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char({8'h00, s[i]});
    endtask

    function automatic logic [CH_W-1:0] path_pick();
        return {8'h00, path_alphabet[$urandom_range(0, path_alphabet.len() - 1)]};
    endfunction

    function automatic logic [CH_W-1:0] scheme_pick();
        return {8'h00, scheme_alphabet[$urandom_range(0, scheme_alphabet.len() - 1)]};
    endfunction

    // Anything at all: full 16-bit range, printable ASCII or a path character.
    function automatic logic [CH_W-1:0] any_pick();
        logic [CH_W-1:0] c;
        case ($urandom_range(0, 3))
            0:       c = CH_W'($urandom_range(0, 16'hFFFF));
            1:       c = CH_W'($urandom_range(16'h0020, 16'h007E));
            default: c = path_pick();
        endcase
        return c;
    endfunction

    // Random character that does not close the current token.
    function automatic logic [CH_W-1:0] free_pick(bit stop_slash, bit stop_qmark);
        logic [CH_W-1:0] c;
        do
            c = any_pick();
        while (c == CH_HASH || (stop_slash && c == CH_SLASH) || (stop_qmark && c == CH_QMARK));
        return c;
    endfunction

    // Well-formed URI with random content and random optional parts.
    task automatic push_uri();
        int unsigned     n_seg;
        bit              lead;
        logic [CH_W-1:0] first;
        if ($urandom_range(0, 1))
        begin
            first = scheme_pick();
            push_char(letter_char(first) ? first : CH_W'("s"));
            repeat ($urandom_range(0, 3)) push_char(scheme_pick());
            push_char(CH_COLON);
        end
        lead = $urandom_range(0, 1);
        if ($urandom_range(0, 2) == 0)
        begin
            push_char(CH_SLASH);
            push_char(CH_SLASH);
            repeat ($urandom_range(0, 4)) push_char(free_pick(1'b1, 1'b1));
            lead = 1'b1;
        end
        n_seg = $urandom_range(0, 3);
        for (int i = 0; i < n_seg; i++)
        begin
            if (i > 0 || lead)
                push_char(CH_SLASH);
            repeat ($urandom_range(0, 4)) push_char(path_pick());
        end
        if ($urandom_range(0, 3) == 0)
            push_char(CH_SLASH);
        if ($urandom_range(0, 2) == 0)
        begin
            push_char(CH_QMARK);
            repeat ($urandom_range(0, 4)) push_char(free_pick(1'b0, 1'b0));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            push_char(CH_HASH);
            repeat ($urandom_range(0, 4)) push_char(any_pick());
        end
        push_end();
    endtask

    task automatic push_noise();
        repeat ($urandom_range(0, 6)) push_char(any_pick());
        push_end();
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and run control
    // ------------------------------------------------------------------
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        int unsigned first_random;

        // Directed strings: empty, scheme only, lone slash, scheme plus lone
        // slash, scheme, authority, empty query and fragment, trailing empty
        // segment, error on the first character, query holding code zero.
        push_end();
        push_text("a:");
        push_end();
        push_text("/");
        push_end();
        push_text("a:/");
        push_end();
        push_text("x://h?#");
        push_char(16'hFFFF);
        push_end();
        push_text("a/");
        push_end();
        push_text("[q");
        push_end();
        push_text("k?");
        push_char(16'h0000);
        push_end();

        // The receiver starts its long hold-off once the random beats begin.
        hold_at = uri_beats.size();

        // Mostly well-formed URIs, with some garbage strings mixed in.
        first_random = uri_beats.size();
        while (uri_beats.size() - first_random < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 5) == 0)
                push_noise();
            else
                push_uri();
        end

        beats_total = uri_beats.size();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        wait (beats_in == beats_total);
        while (expected_events.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_events.size() == 0)
            $display("** uri_component_tokenizer_core: PASSED **");
        else
            $display("** uri_component_tokenizer_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: character beats in bursts of random length with random gaps.
    // Change inputs on the falling edge only.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (item_valid && !in_fire)
        begin
            // hold the offered beat until the core takes it
        end
        else if (gap_left != 0)
        begin
            item_valid <= 1'b0;
            gap_left--;
        end
        else if (uri_beats.size() != 0)
        begin
            next_beat = uri_beats.pop_front();
            ch         <= next_beat.code;
            is_end     <= next_beat.end_mark;
            item_valid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                burst_left--;
            end
        end
        else
        begin
            item_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: alternating ready runs and stalls, plus one long hold-off
    // that lets results pile up until the core drops item_ready.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            res_ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && beats_in >= hold_at)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            res_ready <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                ready_phase = !ready_phase;
                run_left    = ready_phase ? $urandom_range(1, 40) : $urandom_range(1, 6);
            end
            run_left--;
            res_ready <= ready_phase;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard: sample both channels on the rising edge,
    // predict on every accepted character beat, check every result beat.
    // ------------------------------------------------------------------
    task automatic report_failure(string what, result_t want, result_t got);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display({"%0t %s: kind %0d/%0d start %0d/%0d len %0d/%0d seg %0d/%0d",
                      " status %0d/%0d err %0d/%0d last %0d/%0d (expected/actual)"},
                     $time, what, want.kind, got.kind, want.tok_start, got.tok_start,
                     want.tok_len, got.tok_len, want.seg_num, got.seg_num,
                     want.status, got.status, want.error_pos, got.error_pos,
                     want.last, got.last);
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (expected_events.size() == 0)
        begin
            want = '0;
            report_failure("result with nothing expected", want, got);
        end
        else
        begin
            want = expected_events.pop_front();
            if (got.kind !== want.kind || got.tok_start !== want.tok_start ||
                got.tok_len !== want.tok_len || got.seg_num !== want.seg_num ||
                got.status !== want.status || got.error_pos !== want.error_pos ||
                got.last !== want.last)
                report_failure("result mismatch", want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire  = item_valid && item_ready;
            out_fire = res_valid && res_ready;
            // predict first: a beat's results never leave in its own cycle
            if (in_fire)
            begin
                beats_in++;
                predict_beat(ch, is_end);
            end
            if (out_fire)
            begin
                seen.kind      = kind_t'(kind);
                seen.tok_start = tok_start;
                seen.tok_len   = tok_len;
                seen.seg_num   = seg_num;
                seen.status    = status_t'(status);
                seen.error_pos = error_pos;
                seen.last      = last;
                check_result(seen);
            end
            // watchdog: too long without a beat on either side means a hang
            if (in_fire || out_fire)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("** uri_component_tokenizer_core: FAILED **");
                    $finish;
                end
            end
        end
    end

endmodule

FILE: files.f
hdl/uct_pkg.sv
hdl/uri_component_tokenizer_core.sv
verif/testbench.sv
